// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define RTUF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising clk edge, reset included
`define RTUF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/rtuf_pkg.sv =====
// types and constants of the ratio test unique match filter
package rtuf_pkg;

  localparam int DIST_FIELD_W = 10;
  localparam int IDX_W        = 11;
  localparam int RATIO_W      = 9;
  localparam int MAXD_W       = 10;
  localparam int CODE_W       = 3;
  localparam int EPOCH_BITS   = 8;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 4;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 9'd179;
  localparam logic [MAXD_W-1:0]  MAXD_RESET  = 10'd31;

  localparam logic [EPOCH_BITS-1:0] EPOCH_CLEAR = '0;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = 8'd1;
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

  localparam logic [CODE_W-1:0] CODE_OK    = 3'd0;
  localparam logic [CODE_W-1:0] CODE_RATIO = 3'd1;
  localparam logic [CODE_W-1:0] CODE_FAR   = 3'd2;
  localparam logic [CODE_W-1:0] CODE_QSEEN = 3'd3;
  localparam logic [CODE_W-1:0] CODE_TSEEN = 3'd4;

  localparam logic REG_RATIO = 1'b0;
  localparam logic REG_MAXD  = 1'b1;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio_q8;
    logic [MAXD_W-1:0]  max_distance;
  } cfg_t;

endpackage

// ===== rtl/core/rtuf_cfg.sv =====
// apb register file for ratio threshold and distance limit
module rtuf_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rtuf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rtuf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rtuf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output rtuf_pkg::cfg_t                   cfg
);
  import rtuf_pkg::*;

  logic [RATIO_W-1:0] ratio_q8;
  logic [MAXD_W-1:0]  max_distance;
  logic               wr;

  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_q8     <= RATIO_RESET;
      max_distance <= MAXD_RESET;
    end else if (wr) begin
      case (paddr[2])
        REG_RATIO: ratio_q8 <= pwdata[RATIO_W-1:0];
        REG_MAXD:  max_distance <= pwdata[MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RATIO: prdata = CFG_DATA_W'(ratio_q8);
      REG_MAXD:  prdata = CFG_DATA_W'(max_distance);
      default:   prdata = '0;
    endcase
  end

  assign cfg.ratio_q8     = ratio_q8;
  assign cfg.max_distance = max_distance;

endmodule

// ===== rtl/core/rtuf_tag_ram.sv =====
// epoch tag memory, one write port and one registered read port
module rtuf_tag_ram #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read returns the old entry on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/ratio_test_unique_match_filter.sv =====
// top level: ratio test and unique index filter for two-neighbor match records
//
//  channel   dir   fields
//  s_*       in    tuser start_of_set; tdata best, second, query, train
//  m_*       out   tuser accepted, reject_code; tdata match_query, match_train
//  p*        cfg   ratio_q8 at 0x0, max_distance at 0x4
//
// one item per cycle unless stalled; tag ram read and stage 1, then the output register
// seen sets are epoch tags in two tag rams; start_of_set moves to the next epoch
// clearing pass over all MAX_KEYPOINTS entries after reset and whenever the epoch wraps
// (every 254th start_of_set, the 255th after reset); no item is taken during the pass
// a stalled output holds the result; stage 1 takes one input while the output waits
`include "assert_macros.svh"

module ratio_test_unique_match_filter #(
  parameter int MAX_KEYPOINTS = 2048,
  parameter int DIST_BITS     = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // best_distance, second_distance, query_index, train_index
  input  logic [rtuf_pkg::IN_DATA_W-1:0]   s_tdata,
  // start_of_set
  input  logic [rtuf_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // match_query, match_train
  output logic [rtuf_pkg::OUT_DATA_W-1:0]  m_tdata,
  // accepted, reject_code
  output logic [rtuf_pkg::OUT_USER_W-1:0]  m_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rtuf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rtuf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rtuf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import rtuf_pkg::*;

  localparam int ADDR_W = $clog2(MAX_KEYPOINTS);
  localparam int DW     = (DIST_BITS < DIST_FIELD_W) ? DIST_BITS : DIST_FIELD_W;
  localparam int LHS_W  = DW + 8;
  localparam int RHS_W  = DW + RATIO_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_KEYPOINTS - 1);

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_CLEAR = 1'b1;

  cfg_t cfg;

  rtuf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input fields
  logic              in_start;
  logic [DW-1:0]     in_best;
  logic [DW-1:0]     in_second;
  logic [IDX_W-1:0]  in_query;
  logic [IDX_W-1:0]  in_train;

  assign in_start  = s_tuser[0];
  assign in_best   = s_tdata[DW-1:0];
  assign in_second = s_tdata[DIST_FIELD_W +: DW];
  assign in_query  = s_tdata[2*DIST_FIELD_W +: IDX_W];
  assign in_train  = s_tdata[2*DIST_FIELD_W+IDX_W +: IDX_W];

  // control state
  logic                  state;
  logic [ADDR_W-1:0]     clr_addr;
  logic [EPOCH_BITS-1:0] epoch;
  logic [EPOCH_BITS-1:0] epoch_next;

  // stage 1
  logic                  s1_valid;
  logic                  s1_ratio_fail;
  logic                  s1_far;
  logic [IDX_W-1:0]      s1_query;
  logic [IDX_W-1:0]      s1_train;
  logic [EPOCH_BITS-1:0] s1_epoch;

  // last write seen by the item now in stage 1
  logic                  fwd_valid;
  logic [ADDR_W-1:0]     fwd_q_addr;
  logic [ADDR_W-1:0]     fwd_t_addr;
  logic [EPOCH_BITS-1:0] fwd_tag;

  // output register
  logic [CODE_W-1:0]     out_code;
  logic [IDX_W-1:0]      out_query;
  logic [IDX_W-1:0]      out_train;

  logic                  accept;
  logic                  s1_advance;
  logic                  wrap_pending;
  logic                  ratio_fail;
  logic                  far;
  logic [LHS_W-1:0]      lhs;
  logic [RHS_W-1:0]      rhs;
  logic [ADDR_W-1:0]     s1_q_addr;
  logic [ADDR_W-1:0]     s1_t_addr;
  logic [EPOCH_BITS-1:0] q_rdata;
  logic [EPOCH_BITS-1:0] t_rdata;
  logic [EPOCH_BITS-1:0] q_tag;
  logic [EPOCH_BITS-1:0] t_tag;
  logic                  q_bad;
  logic                  t_bad;
  logic [CODE_W-1:0]     s1_code;
  logic                  hit_wr;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_q_waddr;
  logic [ADDR_W-1:0]     ram_t_waddr;
  logic [EPOCH_BITS-1:0] ram_wdata;

  // ratio and distance tests on the incoming item
  assign lhs        = {in_best, 8'b0};
  assign rhs        = cfg.ratio_q8 * in_second;
  assign ratio_fail = !(RHS_W'(lhs) < rhs);
  assign far        = in_best > cfg.max_distance[DW-1:0];

  assign wrap_pending = in_start & (epoch == EPOCH_LAST);
  assign s1_advance   = s1_valid & (!m_tvalid | m_tready);
  assign s_tready     = (state == ST_RUN) & (!s1_valid | s1_advance) & !wrap_pending;
  assign accept       = s_tvalid & s_tready;
  assign epoch_next   = in_start ? epoch + EPOCH_FIRST : epoch;

  // seen lookup in stage 1
  assign s1_q_addr = ADDR_W'(s1_query);
  assign s1_t_addr = ADDR_W'(s1_train);
  assign q_tag = (fwd_valid && fwd_q_addr == s1_q_addr) ? fwd_tag : q_rdata;
  assign t_tag = (fwd_valid && fwd_t_addr == s1_t_addr) ? fwd_tag : t_rdata;
  assign q_bad = (32'(s1_query) >= 32'(MAX_KEYPOINTS)) || (q_tag == s1_epoch);
  assign t_bad = (32'(s1_train) >= 32'(MAX_KEYPOINTS)) || (t_tag == s1_epoch);

  always_comb begin
    if (s1_ratio_fail) begin
      s1_code = CODE_RATIO;
    end else if (s1_far) begin
      s1_code = CODE_FAR;
    end else if (q_bad) begin
      s1_code = CODE_QSEEN;
    end else if (t_bad) begin
      s1_code = CODE_TSEEN;
    end else begin
      s1_code = CODE_OK;
    end
  end

  assign hit_wr      = s1_advance & (s1_code == CODE_OK);
  assign ram_we      = hit_wr | (state == ST_CLEAR);
  assign ram_q_waddr = (state == ST_CLEAR) ? clr_addr : s1_q_addr;
  assign ram_t_waddr = (state == ST_CLEAR) ? clr_addr : s1_t_addr;
  assign ram_wdata   = (state == ST_CLEAR) ? EPOCH_CLEAR : s1_epoch;

  rtuf_tag_ram #(
    .DEPTH  (MAX_KEYPOINTS),
    .ADDR_W (ADDR_W),
    .DATA_W (EPOCH_BITS)
  ) u_query_seen (
    .clk   (clk),
    .re    (accept),
    .raddr (ADDR_W'(in_query)),
    .rdata (q_rdata),
    .we    (ram_we),
    .waddr (ram_q_waddr),
    .wdata (ram_wdata)
  );

  rtuf_tag_ram #(
    .DEPTH  (MAX_KEYPOINTS),
    .ADDR_W (ADDR_W),
    .DATA_W (EPOCH_BITS)
  ) u_train_seen (
    .clk   (clk),
    .re    (accept),
    .raddr (ADDR_W'(in_train)),
    .rdata (t_rdata),
    .we    (ram_we),
    .waddr (ram_t_waddr),
    .wdata (ram_wdata)
  );

  // clearing pass and epoch
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      epoch    <= EPOCH_FIRST;
    end else begin
      case (state)
        ST_RUN: begin
          if (accept) begin
            epoch <= epoch_next;
          end else if (s_tvalid && wrap_pending && !s1_valid) begin
            state    <= ST_CLEAR;
            clr_addr <= '0;
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_RUN;
            epoch <= EPOCH_FIRST;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else if (accept) begin
      s1_valid  <= 1'b1;
      fwd_valid <= hit_wr;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ratio_fail <= ratio_fail;
      s1_far        <= far;
      s1_query      <= in_query;
      s1_train      <= in_train;
      s1_epoch      <= epoch_next;
      fwd_q_addr    <= s1_q_addr;
      fwd_t_addr    <= s1_t_addr;
      fwd_tag       <= s1_epoch;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_code  <= s1_code;
      out_query <= s1_query;
      out_train <= s1_train;
    end
  end

  assign m_tuser = {out_code, out_code == CODE_OK};
  assign m_tdata = {2'b00, out_train, out_query};

  `RTUF_ASSERT(a_no_accept_in_clear, (state == ST_CLEAR) |-> !s_tready, "item taken during clear")
  `RTUF_ASSERT(a_clear_pipe_empty, (state == ST_CLEAR) |-> !s1_valid, "stage busy during clear")
  `RTUF_ASSERT(a_epoch_live, (state == ST_RUN) |-> (epoch != EPOCH_CLEAR), "epoch equals clear tag")
  `RTUF_ASSERT(a_epoch_no_wrap, (accept && in_start) |-> (epoch != EPOCH_LAST), "epoch wrapped")
  `RTUF_ASSERT(a_write_on_ok, hit_wr |=> (m_tvalid && m_tuser[0]), "write without accepted result")

endmodule

// ===== verif/ratio_test_unique_match_filter_tb.sv =====
// testbench for the ratio test unique match filter: directed table, random phases, checks
`timescale 1ns / 1ps

module ratio_test_unique_match_filter_tb;
  import rtuf_pkg::*;

  localparam int NUM_KEYS     = 2048;
  localparam int STALL_MAX    = 15;
  localparam int IDLE_LIMIT   = 12000;
  localparam int DRAIN_CYCLES = 4;
  localparam int N_ROWS       = 20;

  typedef struct packed {
    logic                    start;
    logic [DIST_FIELD_W-1:0] best;
    logic [DIST_FIELD_W-1:0] second;
    logic [IDX_W-1:0]        query;
    logic [IDX_W-1:0]        train;
    logic                    typed;
    logic [CODE_W-1:0]       code;
  } match_rec_t;

  typedef struct packed {
    logic              accepted;
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0]  query;
    logic [IDX_W-1:0]  train;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  ratio_test_unique_match_filter DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [RATIO_W-1:0]  ratio_cfg = RATIO_RESET;
  logic [MAXD_W-1:0]   maxd_cfg  = MAXD_RESET;
  logic [NUM_KEYS-1:0] query_seen = '0;
  logic [NUM_KEYS-1:0] train_seen = '0;

  // newest verdict at the front, oldest at the back
  verdict_t   pending_verdicts[$];
  match_rec_t directed_rows[N_ROWS];
  int         n_rows      = 0;
  int         err_count   = 0;
  int         items_sent  = 0;
  int         sets_opened = 0;
  int         verdicts_seen = 0;
  int         code_hits[5] = '{0, 0, 0, 0, 0};
  bit         idle_on = 1'b1;
  int         out_stall = 0;
  int         quiet_cycles = 0;

  // ratio test, distance limit, then uniqueness of both indices
  function automatic verdict_t judge_match(input match_rec_t r);
    verdict_t    v;
    int unsigned lhs;
    int unsigned rhs;
    if (r.start) begin
      query_seen = '0;
      train_seen = '0;
    end
    lhs = int'(r.best) << 8;
    rhs = int'(ratio_cfg) * int'(r.second);
    if (!(lhs < rhs))
      v.code = CODE_RATIO;
    else if (r.best > maxd_cfg)
      v.code = CODE_FAR;
    else if (query_seen[r.query])
      v.code = CODE_QSEEN;
    else if (train_seen[r.train])
      v.code = CODE_TSEEN;
    else
      v.code = CODE_OK;
    if (v.code == CODE_OK) begin
      query_seen[r.query] = 1'b1;
      train_seen[r.train] = 1'b1;
    end
    v.accepted = (v.code == CODE_OK);
    v.query = r.query;
    v.train = r.train;
    return v;
  endfunction

  function automatic match_rec_t mk_row(input int start, input int best, input int second,
                                        input int query, input int train, input int typed,
                                        input logic [CODE_W-1:0] code);
    match_rec_t r;
    r.start = start[0];
    r.best = best[DIST_FIELD_W-1:0];
    r.second = second[DIST_FIELD_W-1:0];
    r.query = query[IDX_W-1:0];
    r.train = train[IDX_W-1:0];
    r.typed = typed[0];
    r.code = code;
    return r;
  endfunction

  task automatic add_row(input match_rec_t r);
    directed_rows[n_rows] = r;
    n_rows++;
  endtask

  function automatic int unsigned draw_index();
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, NUM_KEYS - 1);
    return $urandom_range(0, 47);
  endfunction

  // mostly records that pass the distance tests, so the seen sets fill up
  function automatic match_rec_t draw_match(input int start_den);
    match_rec_t  r;
    int unsigned mode;
    int unsigned smin;
    r = '0;
    mode = $urandom_range(0, 9);
    r.start = ($urandom_range(1, start_den) == 1);
    r.query = IDX_W'(draw_index());
    r.train = IDX_W'(draw_index());
    if (mode == 0) begin
      r.best = DIST_FIELD_W'($urandom_range(0, 1023));
      r.second = DIST_FIELD_W'($urandom_range(0, 1023));
    end else if (mode == 1) begin
      r.best = DIST_FIELD_W'($urandom_range(0, 1023));
      r.second = '0;
    end else begin
      if (mode == 2)
        r.best = (maxd_cfg == 10'h3FF) ? maxd_cfg :
                 DIST_FIELD_W'(int'(maxd_cfg) + int'($urandom_range(0, 1)));
      else
        r.best = DIST_FIELD_W'($urandom_range(0, int'(maxd_cfg)));
      if (ratio_cfg == '0) begin
        r.second = DIST_FIELD_W'($urandom_range(0, 1023));
      end else begin
        smin = (int'(r.best) * 256) / int'(ratio_cfg) + 1;
        if (smin > 1023)
          r.second = 10'h3FF;
        else if (mode == 3)
          r.second = DIST_FIELD_W'(smin);
        else if (mode == 4)
          r.second = DIST_FIELD_W'(smin - 1);
        else
          r.second = DIST_FIELD_W'($urandom_range(smin, 1023));
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", verdicts_seen, what, got, want);
    err_count++;
  endtask

  task automatic send_item(input match_rec_t r);
    int       gap;
    verdict_t v;
    gap = idle_on ? $urandom_range(0, STALL_MAX) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_DATA_W - 2 * DIST_FIELD_W - 2 * IDX_W){1'b0}},
                r.train, r.query, r.second, r.best};
    s_tuser <= r.start;
    do @(posedge clk); while (!s_tready);
    v = judge_match(r);
    if (r.typed) begin
      v.code = r.code;
      v.accepted = (r.code == CODE_OK);
    end
    pending_verdicts.push_front(v);
    items_sent++;
    if (r.start)
      sets_opened++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_RATIO)
      ratio_cfg = value[RATIO_W-1:0];
    else
      maxd_cfg = value[MAXD_W-1:0];
  endtask

  task automatic run_phase(input int unsigned ratio, input int unsigned maxd, input int count,
                           input int start_den, input bit idle);
    wait_drained();
    write_reg(REG_RATIO, ratio);
    write_reg(REG_MAXD, maxd);
    idle_on = idle;
    for (int i = 0; i < count; i++)
      send_item(draw_match(start_den));
  endtask

  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      out_stall = idle_on ? $urandom_range(0, STALL_MAX) : 0;
      if (out_stall != 0)
        m_tready <= 1'b0;
    end else if (!m_tready) begin
      if (out_stall <= 1)
        m_tready <= 1'b1;
      out_stall--;
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        $display("unexpected result %0d: query %0d train %0d", verdicts_seen,
                 m_tdata[IDX_W-1:0], m_tdata[2*IDX_W-1:IDX_W]);
        err_count++;
      end else begin
        want = pending_verdicts.pop_back();
        if (m_tuser[0] !== want.accepted)
          report_mismatch("accepted", int'(m_tuser[0]), int'(want.accepted));
        if (m_tuser[CODE_W:1] !== want.code)
          report_mismatch("reject_code", int'(m_tuser[CODE_W:1]), int'(want.code));
        if (m_tdata[IDX_W-1:0] !== want.query)
          report_mismatch("match_query", int'(m_tdata[IDX_W-1:0]), int'(want.query));
        if (m_tdata[2*IDX_W-1:IDX_W] !== want.train)
          report_mismatch("match_train", int'(m_tdata[2*IDX_W-1:IDX_W]), int'(want.train));
        if (want.code <= CODE_TSEEN)
          code_hits[want.code]++;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    // reset values of both registers are in force for the whole table
    add_row(mk_row(1, 0, 1, 0, 0, 1, CODE_OK));
    add_row(mk_row(0, 0, 0, 1, 1, 1, CODE_RATIO));
    add_row(mk_row(0, 1023, 1023, 2, 2, 1, CODE_RATIO));
    add_row(mk_row(0, 31, 1023, 2047, 2047, 1, CODE_OK));
    add_row(mk_row(0, 32, 1023, 3, 3, 1, CODE_FAR));
    add_row(mk_row(0, 1, 2, 0, 5, 1, CODE_QSEEN));
    add_row(mk_row(0, 1, 2, 5, 0, 1, CODE_TSEEN));
    add_row(mk_row(0, 1, 2, 0, 0, 1, CODE_QSEEN));
    add_row(mk_row(1, 1, 2, 0, 0, 1, CODE_OK));
    add_row(mk_row(0, 10, 14, 6, 6, 1, CODE_RATIO));
    add_row(mk_row(0, 10, 15, 6, 6, 1, CODE_OK));
    add_row(mk_row(0, 1, 2, 3, 3, 1, CODE_OK));
    add_row(mk_row(0, 0, 1023, 1023, 1024, 0, CODE_OK));
    add_row(mk_row(0, 0, 1, 1024, 1023, 0, CODE_OK));
    add_row(mk_row(0, 21, 682, 1365, 682, 0, CODE_OK));
    add_row(mk_row(0, 10, 341, 682, 1365, 0, CODE_OK));
    add_row(mk_row(1, 1023, 0, 0, 0, 1, CODE_RATIO));
    add_row(mk_row(0, 1, 2, 2047, 2047, 1, CODE_OK));
    add_row(mk_row(0, 0, 1, 7, 7, 1, CODE_OK));
    add_row(mk_row(0, 1, 2, 2047, 7, 1, CODE_QSEEN));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < n_rows; i++)
      send_item(directed_rows[i]);

    run_phase(256, 1023, 150, 32, 1'b1);
    run_phase(0, 0, 60, 16, 1'b0);
    run_phase(511, 1023, 180, 24, 1'b1);
    // every item starts a set, enough to wrap the set counter
    run_phase(179, 31, 320, 1, 1'b1);
    run_phase($urandom_range(1, 511), $urandom_range(0, 1023), 180, 20, 1'b1);
    run_phase(128, 512, 160, 64, 1'b0);

    wait_drained();

    $display("sent %0d items over %0d sets, checked %0d results", items_sent, sets_opened,
             verdicts_seen);
    $display("codes ok %0d ratio %0d far %0d query seen %0d train seen %0d", code_hits[0],
             code_hits[1], code_hits[2], code_hits[3], code_hits[4]);
    if (err_count == 0 && pending_verdicts.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rtuf_pkg.sv
rtl/core/rtuf_cfg.sv
rtl/core/rtuf_tag_ram.sv
rtl/core/ratio_test_unique_match_filter.sv
verif/ratio_test_unique_match_filter_tb.sv
